@@ design/double_ended_queue_core_assert.svh @@
// Assertion macros shared by the deque checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

@@ design/deq_pkg.sv @@
// Shared constants, op codes, command/status structs and ring arithmetic
// for the deque core. No dependencies.
`default_nettype none

package deq_pkg;

    localparam int DEPTH     = 8192;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;
    localparam int OCC_W     = 14;
    localparam int S_FIELD_W = OP_W + WORD_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = 3 * WORD_W + OCC_W + 2;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

    localparam logic [WORD_W-1:0] NONE_WORD = '1;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic exec;      // apply op to pointers, count and cached ends
        logic rd;        // read the new end word from the store
        logic load;      // copy read data into the cached end
        logic out_load;  // load the result register
    } deq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_read; // pop leaves words behind: refill a cached end
        logic out_free;  // result register can take a new beat
    } deq_stat_t;

    // (pos + off) mod DEPTH for pos, off < DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] pos,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, pos} + {1'b0, off};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/deq_ctrl.sv @@
// Sequencing state machine of the deque core.
// Depends on deq_pkg for the command and status structs.
`default_nettype none

module deq_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg    <= ST_EXEC;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    state_reg <= stat.need_read ? ST_READ : ST_DONE;
                end
                ST_READ: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (stat.out_free) begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;

    always_comb begin
        cmd          = '0;
        cmd.accept   = s_tvalid && s_tready_reg;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.rd       = (state_reg == ST_READ);
        cmd.load     = (state_reg == ST_LOAD);
        cmd.out_load = (state_reg == ST_DONE) && stat.out_free;
    end

endmodule

`default_nettype wire

@@ design/deq_datapath.sv @@
// Ring store, pointers, cached end words and result register of the deque.
// Depends on deq_pkg; driven by deq_ctrl commands.
`default_nettype none

module deq_datapath (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  deq_pkg::deq_cmd_t               cmd,
    output deq_pkg::deq_stat_t              stat,
    input  wire [deq_pkg::OP_W-1:0]         in_op,
    input  wire [deq_pkg::WORD_W-1:0]       in_value,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import deq_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]      op_reg;
    logic [WORD_W-1:0]    value_reg;
    logic [ADDR_W-1:0]    head_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [WORD_W-1:0]    head_val_reg;
    logic [WORD_W-1:0]    tail_val_reg;
    logic [WORD_W-1:0]    popped_reg;
    logic                 failed_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              is_full;
    logic              is_zero;
    logic              is_push;
    logic              is_pop;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] head_inc;
    logic [CNT_W-1:0]  tail_off;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_zero  = (count_reg == '0);
    assign is_push  = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_PUSH_BACK);
    assign is_pop   = (op_reg == OP_POP_FRONT) || (op_reg == OP_POP_BACK);
    assign tail_off = count_reg - CNT_W'(1);
    assign head_inc = ring_add(head_reg, ADDR_W'(1));

    // front push goes one slot before head, back push one past the tail
    assign wr_addr = (op_reg == OP_PUSH_FRONT) ? ring_add(head_reg, ADDR_W'(DEPTH - 1))
                                               : ring_add(head_reg, count_reg[ADDR_W-1:0]);
    // after a pop the new end word sits at head or at head + count - 1
    assign rd_addr = (op_reg == OP_POP_FRONT) ? head_reg
                                              : ring_add(head_reg, tail_off[ADDR_W-1:0]);

    assign stat.need_read = is_pop && (count_reg >= CNT_W'(2));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.exec && is_push && !is_full) begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            unique case (op_reg)
                OP_PUSH_FRONT: begin
                    if (!is_full) begin
                        head_reg  <= wr_addr;
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (!is_full) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (!is_zero) begin
                        head_reg  <= head_inc;
                        count_reg <= tail_off;
                    end
                end
                OP_POP_BACK: begin
                    if (!is_zero) begin
                        count_reg <= tail_off;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // cached end words and per-op result flags
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            popped_reg <= NONE_WORD;
            failed_reg <= 1'b0;
            unique case (op_reg)
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        failed_reg <= 1'b1;
                    end else begin
                        head_val_reg <= value_reg;
                        if (is_zero) begin
                            tail_val_reg <= value_reg;
                        end
                    end
                end
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        failed_reg <= 1'b1;
                    end else begin
                        tail_val_reg <= value_reg;
                        if (is_zero) begin
                            head_val_reg <= value_reg;
                        end
                    end
                end
                OP_POP_FRONT: begin
                    if (is_zero) begin
                        failed_reg <= 1'b1;
                    end else begin
                        popped_reg <= head_val_reg;
                    end
                end
                OP_POP_BACK: begin
                    if (is_zero) begin
                        failed_reg <= 1'b1;
                    end else begin
                        popped_reg <= tail_val_reg;
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.load) begin
            if (op_reg == OP_POP_FRONT) begin
                head_val_reg <= rd_data_reg;
            end else begin
                tail_val_reg <= rd_data_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({
                is_zero ? NONE_WORD : tail_val_reg,
                is_zero ? NONE_WORD : head_val_reg,
                is_zero,
                OCC_W'(count_reg),
                failed_reg,
                popped_reg
            });
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ design/double_ended_queue_core.sv @@
// Double-ended queue of 32-bit words over a DEPTH-entry ring store.
// Each input beat carries one op (push front, push back, pop front,
// pop back, peek; codes 5..7 act as peek) and yields exactly one result
// beat with the popped word, a fail flag, the occupancy, an empty flag
// and the front and back words (-1 when empty). Pushes into a full queue
// and pops from an empty one leave the state unchanged and set failed.
// One op is in flight at a time: pushes, peeks and failed ops pass the
// execute and done steps; pops that leave words behind also pass a read
// and a load step, because the new front or back word has to come out of the
// single registered read port of the store before the cached end word is
// refreshed. A result that is not taken holds the next op in its final
// step, but an input beat is accepted while a result still waits.
// The store needs no clearing after reset; only occupied slots are read.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
`default_nettype none

module double_ended_queue_core (
    input  wire                             aclk,
    input  wire                             aresetn,
    // s_tdata: [2:0] op, [34:3] value, [39:35] zero
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [deq_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: [31:0] popped, [32] failed, [46:33] occupancy,
    //          [47] is_empty, [79:48] head_value, [111:80] tail_value
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import deq_pkg::*;

    deq_cmd_t  cmd;
    deq_stat_t stat;

    logic [OP_W-1:0]   in_op;
    logic [WORD_W-1:0] in_value;

    // unpack input beat; padding bits above the fields are ignored
    assign in_op    = s_tdata[OP_W-1:0];
    assign in_value = s_tdata[OP_W+WORD_W-1:OP_W];

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_op    (in_op),
        .in_value (in_value),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ design/deq_checker.sv @@
// Port-level checks for the deque core, bound to the top level.
// Depends on deq_pkg and double_ended_queue_core_assert.svh.
`default_nettype none

`include "double_ended_queue_core_assert.svh"

module deq_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire [deq_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [deq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import deq_pkg::*;

    logic                 res_empty;
    logic [OCC_W-1:0]     res_occ;
    logic [WORD_W-1:0]    res_head;
    logic [WORD_W-1:0]    res_tail;
    logic [S_TDATA_W-1:0] s_seen;

    assign res_empty = m_tdata[WORD_W + 1 + OCC_W];
    assign res_occ   = m_tdata[WORD_W + OCC_W:WORD_W + 1];
    assign res_head  = m_tdata[2*WORD_W + OCC_W + 1:WORD_W + OCC_W + 2];
    assign res_tail  = m_tdata[3*WORD_W + OCC_W + 1:2*WORD_W + OCC_W + 2];
    assign s_seen    = s_tdata;

    // stalled result beat holds
    `DEQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one op in flight: no second input beat right after one is taken
    `DEQ_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready && (s_seen == s_tdata), !s_tready)
    // empty flag agrees with occupancy
    `DEQ_ASSERT_SAME(a_empty_occ, aclk, aresetn, m_tvalid, res_empty == (res_occ == '0))
    // an empty queue reports -1 at both ends
    `DEQ_ASSERT_SAME(a_empty_ends, aclk, aresetn, m_tvalid && res_empty, (res_head == NONE_WORD) && (res_tail == NONE_WORD))

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

`default_nettype wire

@@ test/deq_mirror_pkg.sv @@
// Result prediction and checking for the deque testbench: a mirror of the ring store.
// Depends on deq_pkg for widths, op codes and the empty-end word.
`default_nettype none

package deq_mirror_pkg;

    import deq_pkg::*;

    // Layout of one m_tdata result beat, lowest field last.
    typedef struct packed {
        logic [WORD_W-1:0] tail_value;
        logic [WORD_W-1:0] head_value;
        logic              is_empty;
        logic [OCC_W-1:0]  occupancy;
        logic              failed;
        logic [WORD_W-1:0] popped;
    } deq_reply_t;

    class deque_mirror;
        logic [WORD_W-1:0] ring [DEPTH];
        int                front_slot;
        int                level;
        int                faults;
        deq_reply_t        due_replies [$];

        function new();
            front_slot = 0;
            level      = 0;
            faults     = 0;
        endfunction

        function int slot(int off);
            return (front_slot + off) % DEPTH;
        endfunction

        // Apply one accepted command and queue the reply it must produce.
        function void take_command(logic [OP_W-1:0] op, logic [WORD_W-1:0] word);
            deq_reply_t r;
            r        = '0;
            r.popped = NONE_WORD;
            case (op)
                OP_PUSH_FRONT: begin
                    if (level == DEPTH) begin
                        r.failed = 1'b1;
                    end else begin
                        front_slot       = (front_slot + DEPTH - 1) % DEPTH;
                        ring[front_slot] = word;
                        level++;
                    end
                end
                OP_PUSH_BACK: begin
                    if (level == DEPTH) begin
                        r.failed = 1'b1;
                    end else begin
                        ring[slot(level)] = word;
                        level++;
                    end
                end
                OP_POP_FRONT: begin
                    if (level == 0) begin
                        r.failed = 1'b1;
                    end else begin
                        r.popped   = ring[front_slot];
                        front_slot = slot(1);
                        level--;
                    end
                end
                OP_POP_BACK: begin
                    if (level == 0) begin
                        r.failed = 1'b1;
                    end else begin
                        level--;
                        r.popped = ring[slot(level)];
                    end
                end
                default: begin
                    // peek and spare codes change nothing
                end
            endcase
            r.occupancy = OCC_W'(level);
            r.is_empty  = (level == 0);
            if (level == 0) begin
                r.head_value = NONE_WORD;
                r.tail_value = NONE_WORD;
            end else begin
                r.head_value = ring[front_slot];
                r.tail_value = ring[slot(level - 1)];
            end
            due_replies.insert(due_replies.size(), r);
        endfunction

        function void report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got) begin
                faults++;
                $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                         $time, field, want, got);
            end
        endfunction

        // Compare one result beat with the oldest pending reply.
        function void match_result(logic [M_TDATA_W-1:0] beat);
            deq_reply_t want;
            deq_reply_t got;
            got = deq_reply_t'(beat[M_FIELD_W-1:0]);
            if (due_replies.size() == 0) begin
                faults++;
                $display("%0t: unexpected result, expected none, actual 0x%028h",
                         $time, beat);
                return;
            end
            want = due_replies[0];
            due_replies.delete(0);
            report("popped", want.popped, got.popped);
            report("failed", WORD_W'(want.failed), WORD_W'(got.failed));
            report("occupancy", WORD_W'(want.occupancy), WORD_W'(got.occupancy));
            report("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
            report("head_value", want.head_value, got.head_value);
            report("tail_value", want.tail_value, got.tail_value);
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction
    endclass

endpackage

`default_nettype wire

@@ test/tb_double_ended_queue_core.sv @@
// Self-checking testbench for double_ended_queue_core: directed corner beats,
// then random bursts. Depends on deq_pkg and deq_mirror_pkg.
`default_nettype none

module tb_double_ended_queue_core;

    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;
    import deq_mirror_pkg::*;

    // spare op codes, all handled as peek
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_BEATS = 820;
    localparam int MAX_IDLE     = 11;
    localparam int TAIL_CYCLES  = 12;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    // when clear, neither side inserts idle cycles
    bit pace_on;

    deque_mirror mirror;

    double_ended_queue_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic int draw_gap();
        return pace_on ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    // Mostly full-range words, now and then a boundary pattern.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Drive one command beat; the mirror is updated on the handshake edge.
    // tvalid is only dropped when a gap follows, so back-to-back beats keep it high.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        int                   gap;
        logic [S_TDATA_W-1:0] beat;
        gap  = draw_gap();
        beat = '0;
        beat[OP_W-1:0]      = op;
        beat[OP_W +: WORD_W] = word;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        mirror.take_command(op, word);
    endtask

    task automatic send_push();
        send_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    endtask

    task automatic send_pop();
        send_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
    endtask

    // peek or one of the spare codes
    task automatic send_look();
        send_cmd(OP_W'($urandom_range(int'(OP_PEEK), int'(OP_SPARE_7))), pick_word());
    endtask

    // Result sink: random stall before each beat, tready held high when no stall.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mirror.match_result(m_tdata);
        end
    end

    // Watchdog: the limit is several times the worst-case run of roughly 900
    // beats with random idle gaps on both sides.
    initial begin : watchdog
        #4ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int burst;
        int mode;
        int roll;
        int sent;
        int spin;
        mirror   = new();
        pace_on  = 1'b1;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-queue pops and peek, boundary words at both ends,
        // spare op codes, draining to empty from either side.
        send_cmd(OP_PEEK,       32'h1234_5678);
        send_cmd(OP_POP_FRONT,  32'h0000_0000);
        send_cmd(OP_POP_BACK,   32'hFFFF_FFFF);
        send_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_cmd(OP_PUSH_BACK,  32'h8000_0000);
        send_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH_BACK,  32'h0000_0000);
        send_cmd(OP_PEEK,       32'hDEAD_BEEF);
        send_cmd(OP_SPARE_5,    32'hFFFF_FFFF);
        send_cmd(OP_SPARE_6,    32'h0000_0000);
        send_cmd(OP_SPARE_7,    32'hA5A5_5A5A);
        send_cmd(OP_POP_BACK,   32'h0000_0000);
        send_cmd(OP_POP_FRONT,  32'h0000_0000);
        send_cmd(OP_POP_FRONT,  32'h0000_0000);
        send_cmd(OP_POP_BACK,   32'h0000_0000);
        send_cmd(OP_POP_FRONT,  32'h0000_0000);
        send_cmd(OP_PUSH_BACK,  32'h0000_0001);
        send_cmd(OP_PUSH_FRONT, 32'h5555_5555);
        send_cmd(OP_PUSH_BACK,  32'hAAAA_AAAA);
        send_cmd(OP_POP_FRONT,  32'h0000_0000);
        send_cmd(OP_POP_FRONT,  32'h0000_0000);
        send_cmd(OP_POP_BACK,   32'h0000_0000);
        send_cmd(OP_PEEK,       32'h0000_0000);

        // Random bursts that grow, shrink or churn a small queue, so empty and
        // near-empty states come up often. Idling is switched per burst.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            mode    = $urandom_range(0, 2);
            burst   = $urandom_range(8, 30);
            pace_on = ($urandom_range(0, 3) != 0);
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll >= 90) begin
                    send_look();
                end else if ((mode == 0 && roll < 60) || (mode == 1 && roll < 25)
                             || (mode == 2 && roll < 45)) begin
                    send_push();
                end else begin
                    send_pop();
                end
                sent++;
            end
        end

        s_tvalid <= 1'b0;

        // Let every pending reply come back, then a few quiet cycles.
        spin = 0;
        while (mirror.outstanding() != 0 && spin < 20000) begin
            @(posedge aclk);
            spin++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mirror.outstanding() != 0) begin
            $display("%0t: %0d replies never arrived", $time, mirror.outstanding());
        end
        if (mirror.faults == 0 && mirror.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
